// File: sv/twy_pkg.sv
// Package: types, constants and step functions for the 3-Way block cipher.
`timescale 1ns / 1ps

package twy_pkg;

  typedef logic [2:0][31:0] blk_t;

  localparam logic [4:0]  DEFAULT_ROUNDS = 5'd11;
  localparam logic [15:0] RC_ENC_START   = 16'h0B0B;
  localparam logic [15:0] RC_DEC_START   = 16'hB1B1;
  localparam logic [15:0] RC_POLY_LOW    = 16'h1011;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_IV0   = 3'd3;
  localparam logic [2:0] REG_IV1   = 3'd4;
  localparam logic [2:0] REG_IV2   = 3'd5;
  localparam logic [2:0] REG_ROUND = 3'd6;
  localparam logic [2:0] REG_MODE  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_ROUND,
    ST_FINAL,
    ST_HOLD
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] bitrev_in_bytes(input logic [31:0] a);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 8; i++) begin
        r[b*8 + i] = a[b*8 + 7 - i];
      end
    end
    bitrev_in_bytes = r;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic blk_t bswap_blk(input blk_t s);
    blk_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = bswap(s[i]);
    end
    bswap_blk = r;
  endfunction

  function automatic blk_t step_mu(input blk_t s);
    blk_t r;
    r[0] = bitrev_in_bytes(s[2]);
    r[1] = bitrev_in_bytes(s[1]);
    r[2] = bitrev_in_bytes(s[0]);
    step_mu = r;
  endfunction

  function automatic blk_t step_theta(input blk_t s);
    logic [31:0] c;
    logic [31:0] d0;
    logic [31:0] d1;
    blk_t        r;
    c  = s[0] ^ s[1] ^ s[2];
    c  = rotl(c, 16) ^ rotl(c, 8);
    d0 = (s[0] << 24) ^ (s[2] >> 8) ^ (s[1] << 8) ^ (s[0] >> 24);
    d1 = (s[1] << 24) ^ (s[0] >> 8) ^ (s[2] << 8) ^ (s[1] >> 24);
    r[0] = s[0] ^ c ^ d0;
    r[1] = s[1] ^ c ^ d1;
    r[2] = s[2] ^ c ^ (d0 >> 16) ^ (d1 << 16);
    step_theta = r;
  endfunction

  function automatic blk_t step_pgp(input blk_t s);
    logic [31:0] b2;
    logic [31:0] b0;
    logic [31:0] m;
    blk_t        r;
    b2   = rotl(s[2], 1);
    b0   = rotl(s[0], 22);
    m    = s[1];
    r[0] = rotl(b0 ^ (m | ~b2), 1);
    r[2] = rotl(b2 ^ (b0 | ~m), 22);
    r[1] = m ^ (b2 | ~b0);
    step_pgp = r;
  endfunction

  function automatic logic [15:0] rc_next(input logic [15:0] rc);
    rc_next = {rc[14:0], 1'b0} ^ (rc[15] ? RC_POLY_LOW : 16'h0000);
  endfunction

endpackage

// File: sv/twy_round.sv
// Shared round unit: key and constant add, theta, optional pi-gamma-pi.
`timescale 1ns / 1ps

module twy_round (
  input  twy_pkg::blk_t s_in,
  input  twy_pkg::blk_t key,
  input  logic [15:0]   rc,
  input  logic          pgp_en,
  output twy_pkg::blk_t s_out
);
  import twy_pkg::*;

  blk_t mixed;
  blk_t th;

  always_comb begin
    mixed[0] = s_in[0] ^ key[0] ^ {rc, 16'h0000};
    mixed[1] = s_in[1] ^ key[1];
    mixed[2] = s_in[2] ^ key[2] ^ {16'h0000, rc};
    th       = step_theta(mixed);
    s_out    = pgp_en ? step_pgp(th) : th;
  end

endmodule

// File: sv/threeway_block_cipher_ecb_cbc_unit.sv
// Top level: 3-Way cipher with ECB/CBC chaining around one shared round unit.
// Decrypting takes an extra round-unit pass for the inverse key before the N rounds;
//   N = round count, 0 selects 11. Every round, the key theta and the final theta go
//   through the one round unit, so a new block is accepted only once the last result
//   has moved into the output register.
// Reset (rst_n low, synchronous): key, IV and chain cleared, 11 rounds, ECB encrypt.
`timescale 1ns / 1ps

module threeway_block_cipher_ecb_cbc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_block_word0,
  input  logic [31:0] in_block_word1,
  input  logic [31:0] in_block_word2,
  input  logic        in_first_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2
);
  import twy_pkg::*;

  blk_t        key_r;
  blk_t        iv_r;
  logic [4:0]  rounds_r;
  logic [1:0]  mode_r;
  blk_t        chain_r;
  blk_t        chain_nxt;

  state_t      state_r;
  state_t      state_nxt;

  blk_t        s_r;
  blk_t        s_nxt;
  blk_t        k_r;
  blk_t        k_nxt;
  blk_t        blk_r;
  logic [15:0] rc_r;
  logic [15:0] rc_nxt;
  logic [4:0]  cnt_r;
  logic [4:0]  cnt_nxt;

  blk_t        out_r;
  blk_t        out_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;

  blk_t        unit_s;
  blk_t        unit_k;
  logic [15:0] unit_rc;
  logic        unit_pgp;
  blk_t        unit_out;

  blk_t        blk_in;
  blk_t        chain_eff;
  blk_t        final_res;
  logic        decrypt;
  logic        cbc;
  logic        accept;
  logic        out_free;

  assign decrypt  = mode_r[0];
  assign cbc      = mode_r[1];
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign blk_in   = {in_block_word2, in_block_word1, in_block_word0};

  twy_round u_round (
    .s_in  (unit_s),
    .key   (unit_k),
    .rc    (unit_rc),
    .pgp_en(unit_pgp),
    .s_out (unit_out)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = decrypt ? ST_KEY : ST_ROUND;
      ST_KEY:   state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 5'd1) state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    in_ready = 1'b0;
    unit_s   = s_r;
    unit_k   = k_r;
    unit_rc  = rc_r;
    unit_pgp = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_KEY: begin
        unit_s  = k_r;
        unit_k  = '0;
        unit_rc = 16'h0000;
      end
      ST_ROUND: unit_pgp = 1'b1;
      ST_FINAL: unit_pgp = 1'b0;
      ST_HOLD:  in_ready = 1'b0;
      default:  in_ready = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    s_nxt         = s_r;
    k_nxt         = k_r;
    rc_nxt        = rc_r;
    cnt_nxt       = cnt_r;
    chain_nxt     = chain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    chain_eff     = (cbc && in_first_block) ? iv_r : chain_r;
    final_res     = decrypt ? bswap_blk(step_mu(unit_out)) : unit_out;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cbc) chain_nxt = chain_eff;
          if (decrypt) s_nxt = step_mu(bswap_blk(blk_in));
          else         s_nxt = cbc ? (blk_in ^ chain_eff) : blk_in;
          k_nxt   = key_r;
          rc_nxt  = decrypt ? RC_DEC_START : RC_ENC_START;
          cnt_nxt = (rounds_r == 5'd0) ? DEFAULT_ROUNDS : rounds_r;
        end
      end
      ST_KEY:   k_nxt = bswap_blk(step_mu(unit_out));
      ST_ROUND: begin
        s_nxt   = unit_out;
        rc_nxt  = rc_next(rc_r);
        cnt_nxt = cnt_r - 5'd1;
      end
      ST_FINAL: begin
        if (decrypt && cbc) begin
          s_nxt     = final_res ^ chain_r;
          chain_nxt = blk_r;
        end else begin
          s_nxt = final_res;
          if (cbc) chain_nxt = final_res;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt       = s_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: s_nxt = s_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      iv_r        <= '0;
      chain_r     <= '0;
      rounds_r    <= DEFAULT_ROUNDS;
      mode_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0:  key_r[0] <= cfg_wdata;
          REG_KEY1:  key_r[1] <= cfg_wdata;
          REG_KEY2:  key_r[2] <= cfg_wdata;
          REG_IV0:   iv_r[0]  <= cfg_wdata;
          REG_IV1:   iv_r[1]  <= cfg_wdata;
          REG_IV2:   iv_r[2]  <= cfg_wdata;
          REG_ROUND: rounds_r <= cfg_wdata[4:0];
          REG_MODE:  mode_r   <= cfg_wdata[1:0];
          default:   mode_r   <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    k_r   <= k_nxt;
    rc_r  <= rc_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
    if (accept) blk_r <= blk_in;
  end

  assign out_valid = out_valid_r;
  assign out_word0 = out_r[0];
  assign out_word1 = out_r[1];
  assign out_word2 = out_r[2];

endmodule
